@@ hdl/spq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and controller/datapath interface types for the
// sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH_DEF      = 64;
   localparam int PRIO_WIDTH_DEF = 16;
   localparam int VALUE_WIDTH    = 8;
   localparam int CAP_WIDTH      = 7;
   localparam int COUNT_WIDTH    = 7;
   localparam int STATUS_WIDTH   = 2;

   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 7'd64;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_UNDERFLOW = 2'd2;

   // controller -> datapath step strobes
   typedef struct packed {
      logic accept;     // beat taken on the request side
      logic push_rd;    // read entry at scan index
      logic push_cmp;   // compare read entry, shift it or drop new one in
      logic push_put;   // write new entry at the head
      logic pop_rd;     // read second entry
      logic pop_ld;     // retire head, reload head cache
      logic load_rsp;   // fill the response register
   } dp_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic full;
      logic empty;
      logic gt;         // read entry priority is greater than the new one
      logic idx_zero;   // scan reached the head
   } dp_status_type;

endpackage

@@ hdl/sorted_priority_queue_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded min priority queue kept sorted in a ring memory; lowest priority
// number leaves first, ties leave in arrival order.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake              Beat contents
// req_      in   req_valid/req_ready    cmd, item_value, item_priority
// rsp_      out  rsp_valid/rsp_ready    out_value, out_priority, status,
//                                       is_empty, is_full, entry_count
// csr_      in   csr_wr_en (no wait)    capacity_limit
//
// Push: held entries with a larger priority are scanned from the tail, one
//   memory read and one compare/shift write each, the last scanned entry
//   staying put; a new head is written last. Pop reads the second entry
//   and reloads the head cache; overflow and underflow skip to the response.
// Reset (synchronous): queue empty, capacity 64, no response pending. No
//   clearing pass; the entry memory starts out unwritten.
// One request is worked at a time; a new request is taken while the last
//   response still waits, and completion holds until the response slot frees.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
   parameter int DEPTH      = spq_pkg::DEPTH_DEF,
   parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // capacity register write
   input  logic                              csr_wr_en,
   input  logic [spq_pkg::CAP_WIDTH-1:0]     csr_wr_data,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [spq_pkg::VALUE_WIDTH-1:0]   req_item_value,
   input  logic signed [PRIO_WIDTH-1:0]      req_item_priority,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [spq_pkg::VALUE_WIDTH-1:0]   rsp_out_value,
   output logic signed [PRIO_WIDTH-1:0]      rsp_out_priority,
   output logic [spq_pkg::STATUS_WIDTH-1:0]  rsp_status,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full,
   output logic [spq_pkg::COUNT_WIDTH-1:0]   rsp_entry_count
);

   // step strobes down, flags up
   spq_pkg::dp_cmd_type    dp_cmd;
   spq_pkg::dp_status_type dp_status;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // ring memory with head cache; response register lives here too
   spq_datapath #(
      .DEPTH      (DEPTH),
      .PRIO_WIDTH (PRIO_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_cmd           (req_cmd),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .cmd               (dp_cmd),
      .status            (dp_status),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_status        (rsp_status),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full),
      .rsp_entry_count   (rsp_entry_count)
   );

endmodule

@@ hdl/spq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer for push/pop: issues datapath steps and owns the handshakes.
// ----------------------------------------------------------------------------
module spq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  spq_pkg::dp_status_type status,
   output spq_pkg::dp_cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PUSH_RD,
      S_PUSH_CMP,
      S_PUSH_PUT,
      S_POP_RD,
      S_POP_LD,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_cmd == spq_pkg::CMD_PUSH) begin
                  if (status.full)       state_in = S_DONE;
                  else if (status.empty) state_in = S_PUSH_PUT;
                  else                   state_in = S_PUSH_RD;
               end else begin
                  if (status.empty) state_in = S_DONE;
                  else              state_in = S_POP_RD;
               end
            end
         end
         S_PUSH_RD: begin
            cmd.push_rd = 1'b1;
            state_in    = S_PUSH_CMP;
         end
         S_PUSH_CMP: begin
            cmd.push_cmp = 1'b1;
            if (!status.gt)          state_in = S_DONE;
            else if (status.idx_zero) state_in = S_PUSH_PUT;
            else                      state_in = S_PUSH_RD;
         end
         S_PUSH_PUT: begin
            cmd.push_put = 1'b1;
            state_in     = S_DONE;
         end
         S_POP_RD: begin
            cmd.pop_rd = 1'b1;
            state_in   = S_POP_LD;
         end
         S_POP_LD: begin
            cmd.pop_ld = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // a finished response never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> slot_free)
      else $error("response overwritten");

   // response register is filled only on the way back to idle
   a_load_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> (state_ff == S_IDLE) && rsp_valid_ff)
      else $error("response load without return to idle");

   // a push scan always alternates read then compare
   a_rd_then_cmp: assert property (@(posedge clock) disable iff (reset)
      cmd.push_rd |=> cmd.push_cmp)
      else $error("push read not followed by compare");

endmodule

@@ hdl/spq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath
// Entry memory kept as a sorted ring, head cache, count, capacity register
// and the response register.
// ----------------------------------------------------------------------------
module spq_datapath #(
   parameter int DEPTH      = spq_pkg::DEPTH_DEF,
   parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [spq_pkg::CAP_WIDTH-1:0]          csr_wr_data,
   input  logic                                   req_cmd,
   input  logic [spq_pkg::VALUE_WIDTH-1:0]        req_item_value,
   input  logic signed [PRIO_WIDTH-1:0]           req_item_priority,
   input  spq_pkg::dp_cmd_type                    cmd,
   output spq_pkg::dp_status_type                 status,
   output logic [spq_pkg::VALUE_WIDTH-1:0]        rsp_out_value,
   output logic signed [PRIO_WIDTH-1:0]           rsp_out_priority,
   output logic [spq_pkg::STATUS_WIDTH-1:0]       rsp_status,
   output logic                                   rsp_is_empty,
   output logic                                   rsp_is_full,
   output logic [spq_pkg::COUNT_WIDTH-1:0]        rsp_entry_count
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > spq_pkg::CAP_WIDTH) ? CW : spq_pkg::CAP_WIDTH;
   localparam int VW   = spq_pkg::VALUE_WIDTH;
   localparam int EW   = VW + PRIO_WIDTH;

   localparam logic [AW:0]     DEPTH_W   = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0]   LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [CMPW-1:0] DEPTH_C   = CMPW'(DEPTH);

   // ring address: logical position offset from the head, wrapped once
   function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] base,
                                                input logic [AW-1:0] ofs);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, ofs};
      if (sum >= DEPTH_W) sum = sum - DEPTH_W;
      return sum[AW-1:0];
   endfunction

   logic [EW-1:0] entry_mem [DEPTH];
   logic [EW-1:0] rd_data_ff;

   logic [spq_pkg::CAP_WIDTH-1:0] cap_ff;
   logic [CW-1:0]  count_ff;
   logic [AW-1:0]  head_ptr_ff;
   logic [AW-1:0]  idx_ff;

   logic [VW-1:0]          new_value_ff;
   logic signed [PRIO_WIDTH-1:0] new_prio_ff;
   logic                   is_pop_ff;
   logic [spq_pkg::STATUS_WIDTH-1:0] status_ff;
   logic [VW-1:0]          pop_value_ff;
   logic signed [PRIO_WIDTH-1:0] pop_prio_ff;
   logic [VW-1:0]          head_value_ff;
   logic signed [PRIO_WIDTH-1:0] head_prio_ff;

   logic [VW-1:0]          rd_value;
   logic signed [PRIO_WIDTH-1:0] rd_prio;
   logic [CMPW-1:0]        count_ext;
   logic                   full;
   logic                   empty;
   logic [AW-1:0]          next_pos;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic [AW-1:0] rd_addr;

   assign rd_value  = rd_data_ff[PRIO_WIDTH +: VW];
   assign rd_prio   = rd_data_ff[PRIO_WIDTH-1:0];
   assign count_ext = CMPW'(count_ff);
   assign empty     = (count_ff == '0);
   // capacity above DEPTH clamps to DEPTH
   assign full      = (count_ext >= CMPW'(cap_ff)) || (count_ext >= DEPTH_C);
   assign next_pos  = idx_ff + AW'(1);

   assign status.full     = full;
   assign status.empty    = empty;
   assign status.gt       = rd_prio > new_prio_ff;
   assign status.idx_zero = (idx_ff == '0);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = phys_addr(head_ptr_ff, next_pos);
      wr_data = {new_value_ff, new_prio_ff};
      if (cmd.push_cmp) begin
         wr_en = 1'b1;
         if (status.gt) wr_data = rd_data_ff;   // shift toward tail
      end else if (cmd.push_put) begin
         wr_en   = 1'b1;
         wr_addr = head_ptr_ff;
      end
   end

   assign rd_addr = cmd.pop_rd ? phys_addr(head_ptr_ff, AW'(1))
                               : phys_addr(head_ptr_ff, idx_ff);

   always_ff @(posedge clock) begin
      if (wr_en) entry_mem[wr_addr] <= wr_data;
      rd_data_ff <= entry_mem[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff      <= spq_pkg::CAP_RESET;
         count_ff    <= '0;
         head_ptr_ff <= '0;
      end else begin
         if (csr_wr_en) cap_ff <= csr_wr_data;
         if ((cmd.push_cmp && !status.gt) || cmd.push_put) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.pop_ld) begin
            count_ff    <= count_ff - CW'(1);
            head_ptr_ff <= (head_ptr_ff == LAST_ADDR) ? '0 : head_ptr_ff + AW'(1);
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         new_value_ff <= req_item_value;
         new_prio_ff  <= req_item_priority;
         is_pop_ff    <= (req_cmd == spq_pkg::CMD_POP);
         idx_ff       <= AW'(count_ff - CW'(1));
         if (req_cmd == spq_pkg::CMD_POP) begin
            status_ff    <= empty ? spq_pkg::ST_UNDERFLOW : spq_pkg::ST_OK;
            pop_value_ff <= empty ? '0 : head_value_ff;
            pop_prio_ff  <= empty ? '0 : head_prio_ff;
         end else begin
            status_ff    <= full ? spq_pkg::ST_OVERFLOW : spq_pkg::ST_OK;
         end
      end else if (cmd.push_cmp && status.gt && !status.idx_zero) begin
         idx_ff <= idx_ff - AW'(1);
      end

      if (cmd.push_put) begin
         head_value_ff <= new_value_ff;
         head_prio_ff  <= new_prio_ff;
      end else if (cmd.pop_ld) begin
         head_value_ff <= rd_value;
         head_prio_ff  <= rd_prio;
      end

      if (cmd.load_rsp) begin
         if (is_pop_ff) begin
            rsp_out_value    <= pop_value_ff;
            rsp_out_priority <= pop_prio_ff;
         end else begin
            rsp_out_value    <= empty ? '0 : head_value_ff;
            rsp_out_priority <= empty ? '0 : head_prio_ff;
         end
         rsp_status      <= status_ff;
         rsp_is_empty    <= empty;
         rsp_is_full     <= full;
         rsp_entry_count <= count_ext[spq_pkg::COUNT_WIDTH-1:0];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_cmp || cmd.push_put) |-> !full)
      else $error("insert while full");

   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_ld |=> count_ff == $past(count_ff) - CW'(1))
      else $error("pop did not retire one entry");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_rd |-> !empty)
      else $error("pop sequence on empty queue");

endmodule

@@ sim/spq_order_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_order_checker
// Watches the request, response and capacity ports of the sorted priority
// queue, keeps its own sorted copy of the queue and checks every response
// beat, field by field, against the oldest predicted one.
// ----------------------------------------------------------------------------
module spq_order_checker (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_wr_en,
   input  logic [spq_pkg::CAP_WIDTH-1:0]                 csr_wr_data,
   input  logic                                          req_valid,
   input  logic                                          req_ready,
   input  logic                                          req_cmd,
   input  logic [spq_pkg::VALUE_WIDTH-1:0]               req_item_value,
   input  logic signed [spq_pkg::PRIO_WIDTH_DEF-1:0]     req_item_priority,
   input  logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   input  logic [spq_pkg::VALUE_WIDTH-1:0]               rsp_out_value,
   input  logic signed [spq_pkg::PRIO_WIDTH_DEF-1:0]     rsp_out_priority,
   input  logic [spq_pkg::STATUS_WIDTH-1:0]              rsp_status,
   input  logic                                          rsp_is_empty,
   input  logic                                          rsp_is_full,
   input  logic [spq_pkg::COUNT_WIDTH-1:0]               rsp_entry_count,
   output int                                            mismatches,
   output int                                            pending
);

   localparam int CNT_W = spq_pkg::COUNT_WIDTH;

   typedef struct packed {
      logic [spq_pkg::VALUE_WIDTH-1:0]    value;
      logic [spq_pkg::PRIO_WIDTH_DEF-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic [spq_pkg::VALUE_WIDTH-1:0]    value;
      logic [spq_pkg::PRIO_WIDTH_DEF-1:0] prio;
      logic [spq_pkg::STATUS_WIDTH-1:0]   status;
      logic                               is_empty;
      logic                               is_full;
      logic [spq_pkg::COUNT_WIDTH-1:0]    count;
   } rsp_beat_type;

   entry_type                     held[$];      // sorted, head first
   rsp_beat_type                  due_rsp[$];   // predicted beats, oldest first
   rsp_beat_type                  want;
   logic [spq_pkg::CAP_WIDTH-1:0] capacity;
   int                            rsp_seen;

   task automatic report(input string text);
      $display("[%0t] MISMATCH %s", $realtime, text);
      mismatches = mismatches + 1;
   endtask

   // Applies one request to the local queue and returns the beat it causes.
   function automatic rsp_beat_type serve_request(
         input logic cmd,
         input logic [spq_pkg::VALUE_WIDTH-1:0] value,
         input logic [spq_pkg::PRIO_WIDTH_DEF-1:0] prio);
      rsp_beat_type r;
      entry_type    e;
      int           cap;
      int           pos;
      r   = '0;
      cap = (capacity > spq_pkg::DEPTH_DEF) ? spq_pkg::DEPTH_DEF : int'(capacity);
      if (cmd == spq_pkg::CMD_PUSH) begin
         r.status = spq_pkg::ST_OVERFLOW;
         if (held.size() < cap) begin
            // new entry goes behind every entry of equal or smaller priority
            pos = 0;
            while (pos < held.size() && $signed(held[pos].prio) <= $signed(prio))
               pos++;
            e.value = value;
            e.prio  = prio;
            held.insert(pos, e);
            r.status = spq_pkg::ST_OK;
         end
         if (held.size() > 0) begin
            r.value = held[0].value;
            r.prio  = held[0].prio;
         end
      end else if (held.size() == 0) begin
         r.status = spq_pkg::ST_UNDERFLOW;
      end else begin
         r.value  = held[0].value;
         r.prio   = held[0].prio;
         r.status = spq_pkg::ST_OK;
         void'(held.pop_front());
      end
      r.is_empty = (held.size() == 0);
      r.is_full  = (held.size() >= cap);
      r.count    = CNT_W'(held.size());
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         held.delete();
         due_rsp.delete();
         capacity   = spq_pkg::CAP_RESET;
         rsp_seen   = 0;
         mismatches = 0;
      end else begin
         if (csr_wr_en)
            capacity = csr_wr_data;
         // response first: a beat leaving now never belongs to a request taken now
         if (rsp_valid && rsp_ready) begin
            if (due_rsp.size() == 0) begin
               report($sformatf("beat %0d arrived with nothing outstanding", rsp_seen));
            end else begin
               want = due_rsp.pop_front();
               if (rsp_out_value !== want.value)
                  report($sformatf("beat %0d out_value got %0h want %0h",
                                   rsp_seen, rsp_out_value, want.value));
               if (rsp_out_priority !== want.prio)
                  report($sformatf("beat %0d out_priority got %0d want %0d",
                                   rsp_seen, rsp_out_priority, $signed(want.prio)));
               if (rsp_status !== want.status)
                  report($sformatf("beat %0d status got %0d want %0d",
                                   rsp_seen, rsp_status, want.status));
               if (rsp_is_empty !== want.is_empty)
                  report($sformatf("beat %0d is_empty got %0b want %0b",
                                   rsp_seen, rsp_is_empty, want.is_empty));
               if (rsp_is_full !== want.is_full)
                  report($sformatf("beat %0d is_full got %0b want %0b",
                                   rsp_seen, rsp_is_full, want.is_full));
               if (rsp_entry_count !== want.count)
                  report($sformatf("beat %0d entry_count got %0d want %0d",
                                   rsp_seen, rsp_entry_count, want.count));
            end
            rsp_seen = rsp_seen + 1;
         end
         if (req_valid && req_ready)
            due_rsp.push_back(serve_request(req_cmd, req_item_value, req_item_priority));
      end
      pending <= due_rsp.size();
   end

endmodule

@@ sim/tb_sorted_priority_queue_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_core
// Drives push and pop requests into the sorted priority queue under random
// gaps and response stalls, sweeps the capacity register and leaves the
// checking to spq_order_checker; reports the verdict at the end.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_core;

   localparam int VW  = spq_pkg::VALUE_WIDTH;
   localparam int PW  = spq_pkg::PRIO_WIDTH_DEF;
   localparam int CPW = spq_pkg::CAP_WIDTH;

   // Slowest push walks every held entry. The run limit covers ~650 beats at
   // that cost plus worst gaps and stalls, several times.
   localparam int SETTLE_CYCLES = 2 * spq_pkg::DEPTH_DEF + 16;
   localparam int LIMIT_CYCLES  = 600000;

   logic                                  clock             = 1'b0;
   logic                                  reset             = 1'b1;
   logic                                  csr_wr_en         = 1'b0;
   logic [CPW-1:0]                        csr_wr_data       = '0;
   logic                                  req_valid         = 1'b0;
   logic                                  req_ready;
   logic                                  req_cmd           = spq_pkg::CMD_PUSH;
   logic [VW-1:0]                         req_item_value    = '0;
   logic signed [PW-1:0]                  req_item_priority = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready         = 1'b0;
   logic [VW-1:0]                         rsp_out_value;
   logic signed [PW-1:0]                  rsp_out_priority;
   logic [spq_pkg::STATUS_WIDTH-1:0]      rsp_status;
   logic                                  rsp_is_empty;
   logic                                  rsp_is_full;
   logic [spq_pkg::COUNT_WIDTH-1:0]       rsp_entry_count;

   int mismatches;
   int pending;      // beats predicted but not yet seen, as of the last edge
   int cycles = 0;
   bit gaps_on = 1'b1;   // random idling on both sides

   sorted_priority_queue_core u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_status        (rsp_status),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full),
      .rsp_entry_count   (rsp_entry_count)
   );

   spq_order_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_status        (rsp_status),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full),
      .rsp_entry_count   (rsp_entry_count),
      .mismatches        (mismatches),
      .pending           (pending)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Response side: stall with a chance of about 31 in 100 while gaps are on.
   always @(posedge clock)
      rsp_ready <= !gaps_on || ($urandom_range(99) >= 31);

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("tb_sorted_priority_queue_core NOT OK");
         $finish;
      end
   end

   // Offers one request beat and returns at the edge that takes it. Valid is
   // left high so back-to-back beats never drop it; it falls only on a gap or in drain.
   task automatic send_beat(input logic cmd,
                            input logic [VW-1:0] value,
                            input logic signed [PW-1:0] prio);
      while (gaps_on && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= cmd;
      req_item_value    <= value;
      req_item_priority <= prio;
      do @(posedge clock); while (!req_ready);
   endtask

   // Holds the request side until every predicted beat has come back. The
   // first edge lets the checker count a beat taken at the current edge.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Capacity may only change while the queue engine sits idle.
   task automatic set_capacity(input logic [CPW-1:0] cap);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mix of full-range priorities, a narrow band that forces ties, and the
   // two extremes.
   function automatic logic signed [PW-1:0] rand_prio();
      case ($urandom_range(3))
         0, 1:    rand_prio = PW'($urandom);
         2:       rand_prio = PW'($urandom_range(6)) - 16'sd3;
         default: rand_prio = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      endcase
   endfunction

   // One random phase: fill-heavy first half so the queue reaches capacity
   // and overflows, a short mixed stretch, then drain-heavy until underflow.
   task automatic run_phase(input logic [CPW-1:0] cap, input int beats,
                            input bit gaps);
      int i;
      int push_pct;
      set_capacity(cap);
      gaps_on = gaps;
      for (i = 0; i < beats; i++) begin
         if (i < beats * 45 / 100)
            push_pct = 95;
         else if (i < beats * 55 / 100)
            push_pct = 50;
         else
            push_pct = 5;
         send_beat(($urandom_range(99) < push_pct) ? spq_pkg::CMD_PUSH
                                                   : spq_pkg::CMD_POP,
                   VW'($urandom), rand_prio());
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // --- directed: extremes, ties, empty and full edges -----------------
      send_beat(spq_pkg::CMD_POP,  8'hFF, 16'sh7FFF);   // pop on empty: underflow
      send_beat(spq_pkg::CMD_PUSH, 8'h00, 16'sh7FFF);   // largest priority
      send_beat(spq_pkg::CMD_PUSH, 8'hFF, 16'sh8000);   // smallest priority takes head
      send_beat(spq_pkg::CMD_PUSH, 8'hA5, 16'sh0000);
      send_beat(spq_pkg::CMD_PUSH, 8'h5A, 16'sh0000);   // tie: must leave after A5
      send_beat(spq_pkg::CMD_PUSH, 8'h3C, 16'sh8000);   // tie with head: after FF
      repeat (6) send_beat(spq_pkg::CMD_POP, 8'h00, 16'sh0000);   // five out, then underflow

      set_capacity(7'd1);                               // single slot
      send_beat(spq_pkg::CMD_PUSH, 8'h11, -16'sd1);
      send_beat(spq_pkg::CMD_PUSH, 8'h22, -16'sd2);     // overflow, head unchanged
      send_beat(spq_pkg::CMD_POP,  8'h00, 16'sh0000);
      send_beat(spq_pkg::CMD_POP,  8'h00, 16'sh0000);

      set_capacity(7'd0);                               // zero capacity: always full
      send_beat(spq_pkg::CMD_PUSH, 8'h33, 16'sd7);

      set_capacity(7'd3);
      send_beat(spq_pkg::CMD_PUSH, 8'h44, 16'sd5);
      send_beat(spq_pkg::CMD_PUSH, 8'h55, -16'sd5);
      send_beat(spq_pkg::CMD_PUSH, 8'h66, 16'sd1);

      set_capacity(7'd2);                               // now below the held count
      send_beat(spq_pkg::CMD_PUSH, 8'h77, -16'sd9);     // overflow, nothing dropped
      send_beat(spq_pkg::CMD_POP,  8'h00, 16'sh0000);   // count 2: still full
      send_beat(spq_pkg::CMD_POP,  8'h00, 16'sh0000);   // count 1: room again

      // --- random phases ----------------------------------------------------
      run_phase(7'd64, 150, 1'b1);
      run_phase(7'd1, 40, 1'b1);
      run_phase(7'd127, 150, 1'b0);            // above depth; no idling anywhere
      run_phase(CPW'($urandom_range(63, 2)), 80, 1'b1);
      run_phase(7'd64, 150, 1'b1);
      run_phase(7'd7, 40, 1'b1);

      // --- wrap up ---------------------------------------------------------
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);   // catch any stray late beat
      if (mismatches == 0 && pending == 0)
         $display("tb_sorted_priority_queue_core OK");
      else
         $display("tb_sorted_priority_queue_core NOT OK");
      $finish;
   end

endmodule
